@@ sv/assert_macros.svh @@
// Assertion macros used by the morphology filter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define GMF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define GMF_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) else $error(msg);

`endif

@@ sv/gmf_pkg.sv @@
// Types, constants and helper functions of the grayscale morphology filter.
package gmf_pkg;

   localparam int PIX_W       = 8;
   localparam int KERNEL      = 3;
   localparam int HALF        = KERNEL / 2;
   localparam int WIN_SIZE    = KERNEL * KERNEL;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int ROW_W       = 13;
   localparam int MASK_W      = 9;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int LINE_W      = PIX_W * (KERNEL - 1);
   localparam int TREE_LEAVES = 1 << $clog2(WIN_SIZE);
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [MASK_W-1:0]   MASK_RESET   = MASK_W'(186);

   typedef logic [PIX_W-1:0] pix_type;

   // Configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_DILATE_MODE  = 2'd2,
      CSR_KERNEL_MASK  = 2'd3
   } csr_index_type;

   // Control shared by every window cell
   typedef struct packed {
      logic shift;
      logic dilate;
   } win_ctrl_type;

   // Neutral value of the reduction: 255 for minimum, 0 for maximum
   function automatic pix_type identity_pix(input logic dilate);
      identity_pix = dilate ? '0 : '1;
   endfunction

   // Minimum or maximum of two pixels
   function automatic pix_type pick_pix(input logic dilate, input pix_type a, input pix_type b);
      if (dilate) begin
         pick_pix = (a > b) ? a : b;
      end else begin
         pick_pix = (a < b) ? a : b;
      end
   endfunction

   // Mask bit of a window position; positions beyond the mask are disabled
   function automatic logic mask_bit(input logic [MASK_W-1:0] mask, input int unsigned pos);
      mask_bit = 1'b0;
      if (pos < MASK_W) begin
         mask_bit = mask[pos];
      end
   endfunction

endpackage

@@ sv/grayscale_morphology_filter.sv @@
// Top level of the grayscale erosion/dilation filter.
// The filter takes one pixel item per clock while req_stall is low, and gives one
// result item per item once warm-up is over. A result is registered in turn through
// the line store read, the window shift and store write-back, and the output queue
// write after the combinational masked min/max tree. The line store is a single RAM
// of KERNEL-1 pixels per column, read when an item is accepted and written in the
// next cycle; a same-column hit is forwarded. The input stalls only when the
// four-entry output queue plus the items in flight would fill it, so a stalled
// consumer throttles the source and nothing is lost. The line store needs no
// clearing after reset: its contents only reach border outputs until overwritten.
// Flush items act as black pixels to push out the trailing border; frame_last
// marks the final pixel and the next item starts a new image.
`include "assert_macros.svh"

module grayscale_morphology_filter
   import gmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIX_W-1:0]       req_pixel_in,
   input  logic                   req_flush,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIX_W-1:0]       rsp_pixel_out,
   output logic                   rsp_frame_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // Configuration registers
   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic                dilate_ff;
   logic [MASK_W-1:0]   mask_ff;

   // Input raster position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Read stage
   logic             b_valid_ff, b_emit_ff, b_interior_ff, b_last_ff, b_fwd_ff;
   pix_type          b_pix_ff;
   logic [COL_W-1:0] b_col_ff;
   logic [LINE_W-1:0] b_fwd_data_ff;

   // Reduce stage
   logic c_valid_ff, c_interior_ff, c_last_ff;

   // Output queue
   pix_type                fifo_pix_ff [FIFO_DEPTH];
   logic                   fifo_last_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  fifo_cnt_ff, fifo_cnt_in, occupancy;

   logic [WIDTH_W-1:0]  eff_w;
   logic [HEIGHT_W-1:0] eff_h;
   logic                req_accept, col_wrap, emit, interior, last;
   logic [COL_W-1:0]    cur_col;
   logic [ROW_W-1:0]    cur_row, out_row;
   logic [WIDTH_W-1:0]  out_col, col_inc;
   pix_type             pix;
   logic [LINE_W-1:0]   ram_rd_data, line_rd, line_wr;
   pix_type             column [KERNEL];
   pix_type             win_pix [WIN_SIZE];
   pix_type             win_term [WIN_SIZE];
   pix_type             reduced;
   win_ctrl_type        win_ctrl;
   logic                push, pop;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         dilate_ff <= 1'b0;
         mask_ff   <= MASK_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[HEIGHT_W-1:0];
            CSR_DILATE_MODE:  dilate_ff <= csr_data[0];
            CSR_KERNEL_MASK:  mask_ff   <= csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp the image size to what the line store and kernel allow
   always_comb begin
      if (width_ff < WIDTH_W'(KERNEL)) begin
         eff_w = WIDTH_W'(KERNEL);
      end else if (width_ff > WIDTH_W'(MAX_WIDTH)) begin
         eff_w = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff < HEIGHT_W'(KERNEL)) begin
         eff_h = HEIGHT_W'(KERNEL);
      end else if (height_ff > HEIGHT_W'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   // Hold off the source while the queue and the stages in flight are full
   assign occupancy = fifo_cnt_ff + FIFO_CNT_W'(b_valid_ff & b_emit_ff) + FIFO_CNT_W'(c_valid_ff);
   assign req_stall  = (occupancy >= FIFO_CNT_W'(FIFO_DEPTH));
   assign req_accept = req_valid & ~req_stall;
   assign pix        = req_flush ? '0 : req_pixel_in;

   // Position of the item and of the output it completes
   always_comb begin
      col_wrap = ({1'b0, col_ff} >= eff_w);
      cur_col  = col_wrap ? '0 : col_ff;
      cur_row  = col_wrap ? row_ff + ROW_W'(1) : row_ff;
      emit     = (cur_row > ROW_W'(HALF))
               || ((cur_row == ROW_W'(HALF)) && (cur_col >= COL_W'(HALF)));
      if (cur_col >= COL_W'(HALF)) begin
         out_row = cur_row - ROW_W'(HALF);
         out_col = WIDTH_W'(cur_col) - WIDTH_W'(HALF);
      end else begin
         out_row = cur_row - ROW_W'(HALF) - ROW_W'(1);
         out_col = WIDTH_W'(cur_col) + eff_w - WIDTH_W'(HALF);
      end
      interior = (out_row >= ROW_W'(HALF))
               && (({1'b0, out_row} + (ROW_W+1)'(HALF)) < (ROW_W+1)'(eff_h))
               && (out_col >= WIDTH_W'(HALF))
               && (({1'b0, out_col} + (WIDTH_W+1)'(HALF)) < {1'b0, eff_w});
      last = (out_row >= ROW_W'(eff_h - HEIGHT_W'(1)))
           && ((out_row >= ROW_W'(eff_h)) || (out_col == eff_w - WIDTH_W'(1)));
      col_inc = WIDTH_W'(cur_col) + WIDTH_W'(1);
      if (emit && last) begin
         col_in = '0;
         row_in = '0;
      end else if (col_inc >= eff_w) begin
         col_in = '0;
         row_in = cur_row + ROW_W'(1);
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = cur_row;
      end
   end

   // Advance the raster position on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: KERNEL-1 previous rows per column
   gmf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff),
      .wr_data (line_wr),
      .rd_en   (req_accept),
      .rd_addr (cur_col),
      .rd_data (ram_rd_data)
   );

   // Read stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= req_accept;
      end
   end

   // Read stage payload; catch a write-back to the column being read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_pix_ff      <= pix;
         b_col_ff      <= cur_col;
         b_emit_ff     <= emit;
         b_interior_ff <= interior;
         b_last_ff     <= last;
         b_fwd_ff      <= b_valid_ff && (b_col_ff == cur_col);
         b_fwd_data_ff <= line_wr;
      end
   end

   // Form the new window column and the rows to write back
   always_comb begin
      line_rd = b_fwd_ff ? b_fwd_data_ff : ram_rd_data;
      for (int r = 0; r < KERNEL - 1; r++) begin
         column[r] = line_rd[r*PIX_W +: PIX_W];
      end
      column[KERNEL-1] = b_pix_ff;
      for (int r = 0; r < KERNEL - 2; r++) begin
         line_wr[r*PIX_W +: PIX_W] = line_rd[(r+1)*PIX_W +: PIX_W];
      end
      line_wr[(KERNEL-2)*PIX_W +: PIX_W] = b_pix_ff;
   end

   assign win_ctrl.shift  = b_valid_ff;
   assign win_ctrl.dilate = dilate_ff;

   // Window: KERNEL rows of cells shifting towards column zero
   for (genvar r = 0; r < KERNEL; r++) begin : g_row
      for (genvar c = 0; c < KERNEL; c++) begin : g_col
         pix_type feed;
         if (c == KERNEL - 1) begin : g_edge
            assign feed = column[r];
         end else begin : g_inner
            assign feed = win_pix[r*KERNEL + c + 1];
         end
         gmf_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctrl    (win_ctrl),
            .enable  (mask_bit(mask_ff, r*KERNEL + c)),
            .pix_in  (feed),
            .pix_out (win_pix[r*KERNEL + c]),
            .term    (win_term[r*KERNEL + c])
         );
      end
   end

   gmf_reduce u_reduce (
      .dilate (dilate_ff),
      .terms  (win_term),
      .result (reduced)
   );

   // Reduce stage: only items that complete an output go on
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff & b_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         c_interior_ff <= b_interior_ff;
         c_last_ff     <= b_last_ff;
      end
   end

   // Output queue
   assign push = c_valid_ff;
   assign pop  = rsp_valid & ~rsp_stall;
   assign fifo_cnt_in = fifo_cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
      end
   end

   // Border outputs are zero
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_pix_ff[wr_ptr_ff]  <= c_interior_ff ? reduced : '0;
         fifo_last_ff[wr_ptr_ff] <= c_last_ff;
      end
   end

   assign rsp_valid      = (fifo_cnt_ff != '0);
   assign rsp_pixel_out  = fifo_pix_ff[rd_ptr_ff];
   assign rsp_frame_last = fifo_last_ff[rd_ptr_ff];

   // Credit scheme never lets the queue overflow
   `GMF_ASSERT_ALWAYS(a_queue_bound, occupancy <= FIFO_CNT_W'(FIFO_DEPTH), "output queue overrun")
   // A same-column read right behind a write-back takes the forwarded rows
   `GMF_ASSERT_NEXT(a_forward, req_accept && b_valid_ff && (b_col_ff == cur_col), b_fwd_ff, "missed line store forward")
   // The last output pixel restarts the raster
   `GMF_ASSERT_NEXT(a_frame_restart, req_accept && emit && last, (col_ff == '0) && (row_ff == '0), "frame end did not restart")

endmodule

@@ sv/gmf_ram.sv @@
// Generic simple dual-port RAM with registered read.
module gmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/gmf_cell.sv @@
// One window cell: holds a pixel, takes its neighbour's on shift, masks its term.
module gmf_cell
   import gmf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  win_ctrl_type ctrl,
   input  logic         enable,
   input  pix_type      pix_in,
   output pix_type      pix_out,
   output pix_type      term
);

   pix_type pix_ff;

   // Take the neighbour's pixel when an item moves the window
   always_ff @(posedge clock) begin
      if (reset) begin
         pix_ff <= '0;
      end else if (ctrl.shift) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_out = pix_ff;
   // Disabled positions contribute the neutral value
   assign term = enable ? pix_ff : identity_pix(ctrl.dilate);

endmodule

@@ sv/gmf_reduce.sv @@
// Balanced min/max tree over the masked window terms.
module gmf_reduce
   import gmf_pkg::*;
(
   input  logic    dilate,
   input  pix_type terms [WIN_SIZE],
   output pix_type result
);

   pix_type node [1:2*TREE_LEAVES-1];

   // Fill the leaves, pad with the neutral value, then fold level by level
   always_comb begin
      for (int j = 0; j < TREE_LEAVES; j++) begin
         if (j < WIN_SIZE) begin
            node[TREE_LEAVES + j] = terms[j];
         end else begin
            node[TREE_LEAVES + j] = identity_pix(dilate);
         end
      end
      for (int i = TREE_LEAVES - 1; i >= 1; i--) begin
         node[i] = pick_pix(dilate, node[2*i], node[2*i+1]);
      end
   end

   assign result = node[1];

endmodule

@@ tb/morph_checker.sv @@
// Output checker for the grayscale morphology filter: predicts each filtered pixel and compares.
module morph_checker
   import gmf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  pix_type                req_pixel_in,
   input  logic                   req_flush,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pix_type                rsp_pixel_out,
   input  logic                   rsp_frame_last,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     mismatches,
   output int                     waiting
);

   typedef struct packed {
      pix_type pixel;
      logic    frame_last;
   } filtered_type;

   // Shadow copy of the configuration registers
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic                dilate_reg;
   logic [MASK_W-1:0]   mask_reg;

   // Shadow copy of the filter state
   pix_type     line_rows [KERNEL-1][MAX_WIDTH];
   pix_type     window [WIN_SIZE];
   int unsigned in_col;
   int unsigned in_line;

   filtered_type filtered_pixels [$];
   int           fault_count = 0;

   function automatic int unsigned clamp_dim(input int unsigned size, input int unsigned hi);
      if (size < KERNEL) begin
         return KERNEL;
      end
      if (size > hi) begin
         return hi;
      end
      return size;
   endfunction

   // Masked minimum (erode) or maximum (dilate) over the window
   function automatic pix_type window_extreme();
      pix_type acc;
      acc = dilate_reg ? '0 : '1;
      for (int pos = 0; pos < WIN_SIZE; pos++) begin
         if (pos < MASK_W) begin
            if (mask_reg[pos]) begin
               if (dilate_reg && window[pos] > acc) begin
                  acc = window[pos];
               end else if (!dilate_reg && window[pos] < acc) begin
                  acc = window[pos];
               end
            end
         end
      end
      return acc;
   endfunction

   // Advance the raster by one item and queue the filtered pixel it releases, if any
   task automatic filter_step(input pix_type pixel, input logic flush);
      int unsigned  w, h, x, p, lag, q, total, r, c;
      pix_type      pix;
      pix_type      column [KERNEL];
      filtered_type res;
      w   = clamp_dim(width_reg, MAX_WIDTH);
      h   = clamp_dim(height_reg, MAX_HEIGHT);
      pix = flush ? '0 : pixel;
      if (in_col >= w) begin
         in_col = 0;
         in_line++;
      end
      x = in_col;
      // build the new window column, oldest row first
      for (r = 0; r + 1 < KERNEL; r++) begin
         column[r] = line_rows[r][x];
      end
      column[KERNEL-1] = pix;
      for (r = 0; r < KERNEL; r++) begin
         for (c = 0; c + 1 < KERNEL; c++) begin
            window[r*KERNEL+c] = window[r*KERNEL+c+1];
         end
         window[r*KERNEL+KERNEL-1] = column[r];
      end
      // age the line store column
      for (r = 0; r + 2 < KERNEL; r++) begin
         line_rows[r][x] = line_rows[r+1][x];
      end
      line_rows[KERNEL-2][x] = pix;

      p     = in_line * w + in_col;
      lag   = HALF * w + HALF;
      total = w * h;
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_line++;
      end
      // still filling the window
      if (p < lag) begin
         return;
      end
      q              = p - lag;
      res.frame_last = (q >= total - 1);
      res.pixel      = '0;
      if (q / w >= HALF && q / w + HALF < h && q % w >= HALF && q % w + HALF < w) begin
         res.pixel = window_extreme();
      end
      filtered_pixels.push_back(res);
      if (res.frame_last) begin
         in_col  = 0;
         in_line = 0;
      end
   endtask

   always @(posedge clock) begin
      filtered_type want;
      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         dilate_reg = 1'b0;
         mask_reg   = MASK_RESET;
         in_col     = 0;
         in_line    = 0;
         foreach (window[i]) begin
            window[i] = '0;
         end
         foreach (line_rows[r, c]) begin
            line_rows[r][c] = '0;
         end
         filtered_pixels.delete();
      end else begin
         // compare the result leaving the block with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (filtered_pixels.size() == 0) begin
               $display("%0t: unexpected item, pixel_out %0d frame_last %0b",
                        $time, rsp_pixel_out, rsp_frame_last);
               fault_count++;
            end else begin
               want = filtered_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel) begin
                  $display("%0t: pixel_out expected %0d, actual %0d",
                           $time, want.pixel, rsp_pixel_out);
                  fault_count++;
               end
               if (rsp_frame_last !== want.frame_last) begin
                  $display("%0t: frame_last expected %0b, actual %0b",
                           $time, want.frame_last, rsp_frame_last);
                  fault_count++;
               end
            end
         end
         // track register writes
         if (csr_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg  = csr_data[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_data[HEIGHT_W-1:0];
               CSR_DILATE_MODE:  dilate_reg = csr_data[0];
               CSR_KERNEL_MASK:  mask_reg   = csr_data[MASK_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            filter_step(req_pixel_in, req_flush);
         end
      end
      waiting    <= filtered_pixels.size();
      mismatches <= fault_count;
   end

endmodule

@@ tb/grayscale_morphology_filter_tb.sv @@
// Testbench top of the grayscale morphology filter: stimulus, back-pressure and verdict.
module grayscale_morphology_filter_tb;
   import gmf_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_PAUSE    = 8;
   localparam int END_PAUSE      = 16;
   localparam int LONG_HOLD      = 300;
   localparam int PHASE_ITEMS    = 150;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   pix_type                req_pixel_in = '0;
   logic                   req_flush = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   pix_type                rsp_pixel_out;
   logic                   rsp_frame_last;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int mismatches;
   int waiting;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_requests = 0;
   int idle_cycles = 0;
   int phase_items = 0;
   int img_w;
   int img_h;

   grayscale_morphology_filter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .req_flush      (req_flush),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   morph_checker morph_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .req_flush      (req_flush),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_last (rsp_frame_last),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatches     (mismatches),
      .waiting        (waiting)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver: random stall, or one long hold-off when asked for
   initial begin
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, no item moved", $time);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic int clamp_size(input int raw, input int hi);
      if (raw < KERNEL) begin
         return KERNEL;
      end
      if (raw > hi) begin
         return hi;
      end
      return raw;
   endfunction

   // Offer one item, idling at random first, and hold it until accepted
   task automatic send_item(input pix_type pixel, input logic flush);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pixel;
      req_flush    <= flush;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      phase_items++;
   endtask

   // Drop valid, wait for every predicted item, then let the pipeline empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   // Write all four registers back to back; unused upper data bits are random
   task automatic write_config(input int width_raw, input int height_raw,
                               input logic dilate, input logic [MASK_W-1:0] mask);
      logic [CSR_DATA_W-1:0] words [1 << CSR_INDEX_W];
      csr_index_type         idx;
      wait_idle();
      foreach (words[i]) begin
         words[i] = CSR_DATA_W'($urandom);
      end
      words[CSR_IMAGE_WIDTH][WIDTH_W-1:0]   = WIDTH_W'(width_raw);
      words[CSR_IMAGE_HEIGHT][HEIGHT_W-1:0] = HEIGHT_W'(height_raw);
      words[CSR_DILATE_MODE][0]             = dilate;
      words[CSR_KERNEL_MASK][MASK_W-1:0]    = mask;
      idx = idx.first();
      csr_write <= 1'b1;
      repeat (idx.num()) begin
         csr_index <= idx;
         csr_data  <= words[idx];
         @(posedge clock);
         idx = idx.next();
      end
      csr_write <= 1'b0;
      img_w = clamp_size(width_raw, MAX_WIDTH);
      img_h = clamp_size(height_raw, MAX_HEIGHT);
   endtask

   // Pick a mostly small image size, sometimes below the clamp, and a random filter
   task automatic random_config();
      int                wr, hr;
      logic [MASK_W-1:0] mask;
      case ($urandom_range(19))
         0:       wr = $urandom_range(2);
         1:       wr = $urandom_range(40, 13);
         default: wr = $urandom_range(12, 3);
      endcase
      case ($urandom_range(19))
         0:       hr = $urandom_range(2);
         1:       hr = $urandom_range(10, 7);
         default: hr = $urandom_range(6, 3);
      endcase
      case ($urandom_range(7))
         0:       mask = '0;
         1:       mask = '1;
         2:       mask = MASK_RESET;
         default: mask = MASK_W'($urandom);
      endcase
      write_config(wr, hr, 1'($urandom), mask);
   endtask

   // One image in raster order, then the flush tail; some tail items are spare pixels
   task automatic send_image();
      pix_type px;
      repeat (img_w * img_h) begin
         case ($urandom_range(9))
            0:       px = '0;
            1:       px = '1;
            default: px = pix_type'($urandom);
         endcase
         send_item(px, 1'b0);
      end
      repeat (HALF * img_w + HALF) begin
         send_item(pix_type'($urandom), ($urandom_range(5) != 0));
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic long_hold);
      logic hold_pending;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      phase_items   = 0;
      hold_pending  = long_hold;
      while (phase_items < PHASE_ITEMS) begin
         if ($urandom_range(1) == 0) begin
            random_config();
         end
         // start the long hold-off only once items are about to flow
         if (hold_pending) begin
            hold_requests++;
            hold_pending = 1'b0;
         end
         send_image();
      end
   endtask

   initial begin
      pix_type corner_image [9];
      corner_image = '{8'd0, 8'd255, 8'd255, 8'd100, 8'd200, 8'd255, 8'd255, 8'd255, 8'd0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 67;

      // smallest image via clamped zero sizes, cross erosion, spare pixels in the tail
      write_config(0, 0, 1'b0, MASK_RESET);
      foreach (corner_image[i]) begin
         send_item(corner_image[i], 1'b0);
      end
      send_item(8'hFF, 1'b1);
      send_item(8'hAA, 1'b0);
      send_item(8'h55, 1'b1);
      send_item(8'h00, 1'b0);

      // tallest height, empty mask, then shrink the height mid-image to force a frame end
      write_config(3, 8191, 1'b1, '0);
      repeat (12) send_item(pix_type'($urandom), 1'b0);
      write_config(3, 3, 1'b0, '0);
      send_item(8'h80, 1'b0);

      // random phases with changing back-pressure
      run_phase(34, 67, 1'b0);
      run_phase(67, 34, 1'b1);
      run_phase(0, 0, 1'b1);

      wait_idle();
      repeat (END_PAUSE) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
